// File: design/slsd_pkg.sv
`timescale 1ns / 1ps

package slsd_pkg;

    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_GOOD    = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic [7:0] SYNC_RESET = 8'hAA;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] command;
        logic [7:0] payload_length;
        logic [7:0] byte_index;
        logic [7:0] payload_byte;
        logic       packet_end;
    } t_result;

endpackage

// File: design/slsd_step.sv
`timescale 1ns / 1ps

module slsd_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_sync_byte,
    output logic               o_res_valid,
    output slsd_pkg::t_result  o_res
);
    import slsd_pkg::*;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_COMMAND = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [2:0] r_phase,         n_phase;
    logic [7:0] r_held_command,  n_held_command;
    logic [7:0] r_held_length,   n_held_length;
    logic [7:0] r_payload_count, n_payload_count;
    logic [7:0] r_running_sum,   n_running_sum;
    logic [7:0] w_sum_add;
    logic [7:0] w_count_inc;

    assign w_sum_add   = r_running_sum + i_byte;
    assign w_count_inc = r_payload_count + 8'd1;

    always_comb begin
        n_phase         = r_phase;
        n_held_command  = r_held_command;
        n_held_length   = r_held_length;
        n_payload_count = r_payload_count;
        n_running_sum   = r_running_sum;
        o_res_valid     = 1'b0;
        o_res.status         = ST_PAYLOAD;
        o_res.command        = r_held_command;
        o_res.payload_length = r_held_length;
        o_res.byte_index     = 8'd0;
        o_res.payload_byte   = 8'd0;
        o_res.packet_end     = 1'b0;
        unique case (r_phase)
            PH_COMMAND: begin
                n_held_command = i_byte;
                n_running_sum  = i_byte;
                n_phase        = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_held_length   = i_byte;
                n_running_sum   = w_sum_add;
                n_payload_count = 8'd0;
                n_phase         = (i_byte != 8'd0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA: begin
                n_running_sum   = w_sum_add;
                n_payload_count = w_count_inc;
                // count stays below length here, so the increment cannot wrap
                if (w_count_inc >= r_held_length) begin
                    n_phase = PH_CHECK;
                end
                o_res_valid        = 1'b1;
                o_res.byte_index   = r_payload_count;
                o_res.payload_byte = i_byte;
            end
            PH_CHECK: begin
                o_res_valid      = 1'b1;
                o_res.status     = (r_running_sum == i_byte) ? ST_GOOD : ST_BAD;
                o_res.packet_end = 1'b1;
                n_phase          = PH_HUNT;
            end
            default: begin
                n_phase = (i_byte == i_sync_byte) ? PH_COMMAND : PH_HUNT;
            end
        endcase
        if (!i_fire) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT;
            r_held_command  <= 8'd0;
            r_held_length   <= 8'd0;
            r_payload_count <= 8'd0;
            r_running_sum   <= 8'd0;
        end else if (i_fire) begin
            r_phase         <= n_phase;
            r_held_command  <= n_held_command;
            r_held_length   <= n_held_length;
            r_payload_count <= n_payload_count;
            r_running_sum   <= n_running_sum;
        end
    end

endmodule

// File: design/sync_length_sum_deframer.sv
`timescale 1ns / 1ps

// Packet deframer for a serial byte stream: sync byte, command, length, payload,
// then an 8-bit wrapping-sum check byte. Every payload byte comes out as its own
// result with its index; the check byte gives one verdict result (good or
// checksum error, packet_end set). One byte is taken per cycle while o_in_stall is
// low; each byte is held in the input register and its result in the output
// register. The state update is combinational 8-bit adds and compares between
// the two registers. o_in_stall rises only when the output register is full and
// stalled.
module sync_length_sum_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_command,
    output logic [7:0] o_payload_length,
    output logic [7:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_packet_end
);
    import slsd_pkg::*;

    logic [7:0] r_sync;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_out_free;
    logic       w_fire;
    logic       w_res_valid;
    t_result    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
        end else if (i_cfg_we) begin
            r_sync <= i_cfg_data;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    slsd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (r_in_byte),
        .i_sync_byte (r_sync),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_command        = r_out.command;
    assign o_payload_length = r_out.payload_length;
    assign o_byte_index     = r_out.byte_index;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_packet_end     = r_out.packet_end;

endmodule

// File: design/slsd_checker.sv
`timescale 1ns / 1ps

module slsd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_in_stall,
    input  logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] o_status,
    input  logic [7:0] o_byte_index,
    input  logic [7:0] o_payload_byte,
    input  logic       o_packet_end
);
    import slsd_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_payload_byte) && $stable(o_packet_end))
        else $error("result changed while stalled");

    a_end_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_packet_end == (o_status != ST_PAYLOAD)))
        else $error("packet_end disagrees with status");

    a_verdict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_end |-> o_byte_index == 8'd0 && o_payload_byte == 8'd0)
        else $error("verdict carries payload data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_PAYLOAD || o_status == ST_GOOD
            || o_status == ST_BAD))
        else $error("undefined status code");

    // input side only backs up behind a stalled, full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind sync_length_sum_deframer slsd_checker u_slsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_byte_index   (o_byte_index),
    .o_payload_byte (o_payload_byte),
    .o_packet_end   (o_packet_end)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import slsd_pkg::*;

    typedef enum logic [2:0] {
        WAIT_SYNC,
        TAKE_CMD,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_CHECK
    } deframe_phase_e;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_cfg_we         = 1'b0;
    logic [7:0] i_cfg_data       = 8'h00;
    logic       i_in_valid       = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_rx_byte        = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall      = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_command;
    logic [7:0] o_payload_length;
    logic [7:0] o_byte_index;
    logic [7:0] o_payload_byte;
    logic       o_packet_end;

    sync_length_sum_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_byte_index     (o_byte_index),
        .o_payload_byte   (o_payload_byte),
        .o_packet_end     (o_packet_end)
    );

    always #5 i_clk = ~i_clk;

    // bytes waiting to be sent, and deframer outputs predicted but not yet seen
    logic [7:0]     rx_pending[$];
    t_result        deframed_q[$];

    // predictor state
    logic [7:0]     frame_sync    = SYNC_RESET;
    deframe_phase_e pred_phase    = WAIT_SYNC;
    logic [7:0]     pred_command  = 8'h00;
    logic [7:0]     pred_length   = 8'h00;
    logic [7:0]     pred_count    = 8'h00;
    logic [7:0]     pred_sum      = 8'h00;

    int  errors       = 0;
    int  frames_sent  = 0;
    int  payload_seen = 0;
    int  good_seen    = 0;
    int  bad_seen     = 0;
    int  in_gap       = 0;
    int  out_gap      = 0;
    bit  no_idle      = 1'b0;

    task automatic deframe_byte(input logic [7:0] b);
        t_result r;
        begin
            r = '0;
            case (pred_phase)
                TAKE_CMD: begin
                    pred_command = b;
                    pred_sum     = b;
                    pred_phase   = TAKE_LEN;
                end
                TAKE_LEN: begin
                    pred_length = b;
                    pred_sum    = pred_sum + b;
                    pred_count  = 8'h00;
                    pred_phase  = (b != 8'h00) ? TAKE_DATA : TAKE_CHECK;
                end
                TAKE_DATA: begin
                    r.status         = ST_PAYLOAD;
                    r.command        = pred_command;
                    r.payload_length = pred_length;
                    r.byte_index     = pred_count;
                    r.payload_byte   = b;
                    r.packet_end     = 1'b0;
                    deframed_q.push_back(r);
                    pred_sum   = pred_sum + b;
                    pred_count = pred_count + 8'h01;
                    if (pred_count >= pred_length)
                        pred_phase = TAKE_CHECK;
                end
                TAKE_CHECK: begin
                    r.status         = (pred_sum == b) ? ST_GOOD : ST_BAD;
                    r.command        = pred_command;
                    r.payload_length = pred_length;
                    r.packet_end     = 1'b1;
                    deframed_q.push_back(r);
                    pred_phase = WAIT_SYNC;
                end
                default: begin
                    pred_phase = (b == frame_sync) ? TAKE_CMD : WAIT_SYNC;
                end
            endcase
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                deframe_byte(i_rx_byte);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!no_idle && rx_pending.size() > 0
                             && $urandom_range(0, 15) == 0) begin
                    in_gap = $urandom_range(0, 14);
                    i_in_valid <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= rx_pending.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        begin
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (deframed_q.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual status %0h",
                             $time, o_status);
                    errors++;
                end else begin
                    want = deframed_q.pop_front();
                    check_field("status", 8'(want.status), 8'(o_status));
                    check_field("command", want.command, o_command);
                    check_field("payload_length", want.payload_length, o_payload_length);
                    check_field("byte_index", want.byte_index, o_byte_index);
                    check_field("payload_byte", want.payload_byte, o_payload_byte);
                    check_field("packet_end", 8'(want.packet_end), 8'(o_packet_end));
                    if (want.status == ST_PAYLOAD)
                        payload_seen++;
                    else if (want.status == ST_GOOD)
                        good_seen++;
                    else
                        bad_seen++;
                end
            end
            if (out_gap == 0 && !no_idle && $urandom_range(0, 19) == 0)
                out_gap = $urandom_range(1, 15);
            if (out_gap > 0) begin
                out_gap = out_gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_frame(input logic [7:0] cmd, input int len, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] data;
        logic [7:0] flip;
        begin
            rx_pending.push_back(frame_sync);
            rx_pending.push_back(cmd);
            rx_pending.push_back(len[7:0]);
            sum = cmd + len[7:0];
            for (int k = 0; k < len; k++) begin
                data = 8'($urandom);
                rx_pending.push_back(data);
                sum = sum + data;
            end
            if (corrupt) begin
                flip = 8'($urandom_range(1, 255));
                sum  = sum ^ flip;
            end
            rx_pending.push_back(sum);
            frames_sent++;
        end
    endtask

    // mostly clean frames; some line noise and frames cut short after the command
    task automatic queue_traffic(input int target);
        int         n;
        int         pick;
        int         len;
        logic [7:0] junk;
        begin
            n = 0;
            while (n < target) begin
                pick = $urandom_range(0, 19);
                junk = 8'($urandom);
                if (pick < 2) begin
                    rx_pending.push_back(junk);
                end else if (pick == 2) begin
                    rx_pending.push_back(frame_sync);
                    rx_pending.push_back(junk);
                    n += 2;
                end else begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                      : $urandom_range(0, 6);
                    queue_frame(8'($urandom), len, $urandom_range(0, 4) == 0);
                    n += len + 4;
                end
            end
        end
    endtask

    // sender holds off until the deframer has gone quiet
    task automatic wait_drained;
        begin
            do @(negedge i_clk);
            while (rx_pending.size() != 0 || i_in_valid || deframed_q.size() != 0);
            repeat (4) @(negedge i_clk);
        end
    endtask

    task automatic write_sync(input logic [7:0] value);
        begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_data <= value;
            @(posedge i_clk);
            i_cfg_we   <= 1'b0;
            frame_sync = value;
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: ignored bytes, zero-length frames, extreme bytes, sync value as data
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(SYNC_RESET);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(SYNC_RESET);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'h01);
        rx_pending.push_back(SYNC_RESET);
        rx_pending.push_back(8'h12);
        rx_pending.push_back(8'h02);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'h13);
        rx_pending.push_back(SYNC_RESET);
        rx_pending.push_back(SYNC_RESET);
        rx_pending.push_back(8'h01);
        rx_pending.push_back(SYNC_RESET);
        rx_pending.push_back(8'h54);
        frames_sent += 4;
        queue_traffic(100);
        wait_drained();

        write_sync(8'h00);
        queue_frame(8'($urandom), 255, 1'b0);
        queue_traffic(100);
        wait_drained();

        write_sync(8'hFF);
        queue_frame(8'($urandom), $urandom_range(64, 127), $urandom_range(0, 1) == 1);
        queue_traffic(100);
        wait_drained();

        // last stretch runs back to back
        no_idle = 1'b1;
        write_sync(8'($urandom));
        queue_traffic(150);
        wait_drained();

        $display("Sent %0d frames over 4 sync settings with noise and truncation.", frames_sent);
        $display("Checked %0d payload, %0d good and %0d bad verdict transfers.",
                 payload_seen, good_seen, bad_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
design/slsd_pkg.sv
design/slsd_step.sv
design/sync_length_sum_deframer.sv
design/slsd_checker.sv
verif/tb_top.sv
